// ----- sv/one_euro_filter_defines.svh -----
// ============================================================================
// One Euro filter assertion macros
// Shared assertion forms for the filter RTL, clocked on clock and held off
// during reset.
// ============================================================================
`ifndef ONE_EURO_FILTER_DEFINES_SVH
`define ONE_EURO_FILTER_DEFINES_SVH

// Same-cycle implication.
`define OEF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OEF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/oef_pkg.sv -----
// ============================================================================
// One Euro filter package
// Sequencer states, register indexes and fixed constants of the filter.
// ============================================================================
package oef_pkg;

   // Shared shift-add / shift-subtract datapath width.
   localparam int ACC_W = 81;

   localparam logic [1:0] CSR_MIN_CUTOFF   = 2'd0;
   localparam logic [1:0] CSR_SPEED_GAIN   = 2'd1;
   localparam logic [1:0] CSR_DERIV_CUTOFF = 2'd2;

   localparam logic [15:0] MIN_CUTOFF_RST   = 16'd256;
   localparam logic [31:0] SPEED_GAIN_RST   = 32'd1311;
   localparam logic [15:0] DERIV_CUTOFF_RST = 16'd256;

   localparam logic [19:0] US_DEFAULT  = 20'd1000;
   localparam logic [19:0] US_PER_SEC  = 20'd1000000;
   localparam logic [22:0] TWO_PI_Q20  = 23'd6588397;
   localparam logic [55:0] ONE_SEC_Q36 = 56'(64'd1000000 << 36);

   localparam logic [47:0] SPEED_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SPEED_MIN = 48'h8000_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_SPD_MUL,
      ST_SPD_DIV,
      ST_SPD_SAT,
      ST_AL_SETUP,
      ST_AL_MUL,
      ST_AL_NORM,
      ST_AL_PMUL,
      ST_AL_DSET,
      ST_AL_DIV,
      ST_BL_MUL,
      ST_BL_END,
      ST_GAIN_SET,
      ST_GAIN_MUL,
      ST_CUT,
      ST_OUT
   } state_type;

endpackage

// ----- sv/one_euro_filter.sv -----
// ============================================================================
// One Euro filter
// Adaptive low-pass filter over one fixed-point sample stream, computed on a
// single bit-serial multiply and divide datapath.
// ============================================================================
// The filter takes one item at a time. A first sample (after reset or with
// req_restart set) passes through unchanged: it goes through the start and
// output states, and the next input can be taken in the cycle its result
// becomes valid. Every other sample runs through one shared bit-serial
// datapath that retires one multiplier bit or one quotient bit per cycle.
// That covers the 53-step speed divide, eight shift-add multiplies, the two
// 16-step alpha divides and one normalizing shift per halving of the
// time-cutoff product. The number of normalizing shifts depends on the data.
// Here too the next input can be taken in the cycle the result becomes valid.
// A result waiting in the output register does not block the next input
// transfer, but that sample's result waits until the output register is
// free. Configuration writes are always taken and must only be issued while
// the filter is idle.

`include "one_euro_filter_defines.svh"

module one_euro_filter
   import oef_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample,
   input  logic        [19:0] req_elapsed_us,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_filtered,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_wdata
);

   state_type state_ff, state_in;

   logic              primed_ff, primed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       min_cut_ff, min_cut_in;
   logic [31:0]       gain_ff, gain_in;
   logic [15:0]       dcut_ff, dcut_in;
   logic [31:0]       est_ff, est_in;
   logic [47:0]       spd_ff, spd_in;

   logic [31:0]       rsp_filtered_ff, rsp_filtered_in;
   logic [31:0]       x_ff, x_in;
   logic [19:0]       us_ff, us_in;
   logic              restart_ff, restart_in;
   logic              neg_ff, neg_in;
   logic              pass_ff, pass_in;
   logic [47:0]       speed_ff, speed_in;
   logic [31:0]       cut_ff, cut_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  mcand_ff, mcand_in;
   logic [31:0]       mpl_ff, mpl_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [19:0]       rem_ff, rem_in;
   logic [55:0]       c_ff, c_in;

   // Datapath terms.
   logic [ACC_W-1:0]  mac_sum;
   logic              last_step;
   logic [32:0]       diff;
   logic [32:0]       mag;
   logic [20:0]       rem_sh;
   logic              div_ge;
   logic [20:0]       rem_sub;
   logic [52:0]       quo;
   logic              big_neg;
   logic              big_pos;
   logic [31:0]       fc;
   logic [64:0]       r2;
   logic [64:0]       d65;
   logic [64:0]       r2_sub;
   logic              al_ge;
   logic [15:0]       alpha;
   logic [48:0]       bl_new;
   logic [48:0]       bl_old;
   logic [48:0]       dv;
   logic [48:0]       bl_res;
   logic [47:0]       smag;
   logic [63:0]       prod;
   logic [32:0]       cut_sum;
   logic              cut_sat;
   logic              in_xfer;
   logic              in_loop;
   logic              al_rem_ok;

   assign req_stall    = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   always_comb begin
      // One multiplier bit per cycle, MSB first.
      mac_sum   = {acc_ff[ACC_W-2:0], 1'b0} + (mpl_ff[31] ? mcand_ff : '0);
      last_step = (cnt_ff == 6'd1);

      diff = {x_ff[31], x_ff} - {est_ff[31], est_ff};
      mag  = diff[32] ? 33'(33'd0 - diff) : diff;

      // Restoring divide of the scaled difference by the elapsed time.
      rem_sh  = {rem_ff, acc_ff[52]};
      div_ge  = (rem_sh >= {1'b0, us_ff});
      rem_sub = rem_sh - {1'b0, us_ff};

      quo     = acc_ff[52:0];
      big_neg = (|quo[52:48]) || (quo[47] && (|quo[46:0]));
      big_pos = |quo[52:47];

      fc = pass_ff ? cut_ff : {8'd0, dcut_ff, 8'd0};

      // Alpha divide: remainder always stays below the divisor.
      r2     = {acc_ff[63:0], 1'b0};
      d65    = {2'd0, mcand_ff[62:0]};
      r2_sub = r2 - d65;
      al_ge  = (r2 >= d65);
      alpha  = {mpl_ff[14:0], al_ge};

      bl_new = pass_ff ? {{17{x_ff[31]}}, x_ff} : {speed_ff[47], speed_ff};
      bl_old = pass_ff ? {{17{est_ff[31]}}, est_ff} : {spd_ff[47], spd_ff};
      dv     = bl_new - bl_old;
      // floor((a*v + (1-a)*o)) equals o + floor(a*(v-o)).
      bl_res = acc_ff[64:16] + bl_old;

      smag = spd_ff[47] ? 48'(48'd0 - spd_ff) : spd_ff;

      prod    = acc_ff[63:0] >> FRAC_BITS;
      cut_sum = {9'd0, min_cut_ff, 8'd0} + {1'b0, prod[31:0]};
      cut_sat = (|acc_ff[ACC_W-1:64]) || (|prod[63:32]) || cut_sum[32];

      in_xfer   = req_valid && !req_stall;
      in_loop   = (state_ff == ST_SPD_MUL) || (state_ff == ST_SPD_DIV) ||
                  (state_ff == ST_AL_MUL) || (state_ff == ST_AL_PMUL) ||
                  (state_ff == ST_AL_DIV) || (state_ff == ST_BL_MUL) ||
                  (state_ff == ST_GAIN_MUL);
      al_rem_ok = (acc_ff[63:0] < mcand_ff[63:0]);
   end

   always_comb begin
      state_in        = state_ff;
      primed_in       = primed_ff;
      min_cut_in      = min_cut_ff;
      gain_in         = gain_ff;
      dcut_in         = dcut_ff;
      est_in          = est_ff;
      spd_in          = spd_ff;
      rsp_filtered_in = rsp_filtered_ff;
      x_in            = x_ff;
      us_in           = us_ff;
      restart_in      = restart_ff;
      neg_in          = neg_ff;
      pass_in         = pass_ff;
      speed_in        = speed_ff;
      cut_in          = cut_ff;
      acc_in          = acc_ff;
      mcand_in        = mcand_ff;
      mpl_in          = mpl_ff;
      cnt_in          = cnt_ff;
      rem_in          = rem_ff;
      c_in            = c_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_CUTOFF:   min_cut_in = csr_wdata[15:0];
            CSR_SPEED_GAIN:   gain_in    = csr_wdata;
            CSR_DERIV_CUTOFF: dcut_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in       = req_sample;
               us_in      = (req_elapsed_us == 20'd0) ? US_DEFAULT : req_elapsed_us;
               restart_in = req_restart;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            if (!primed_ff || restart_ff) begin
               primed_in = 1'b1;
               est_in    = x_ff;
               spd_in    = '0;
               state_in  = ST_OUT;
            end else begin
               pass_in  = 1'b0;
               neg_in   = diff[32];
               mcand_in = ACC_W'(mag);
               mpl_in   = {US_PER_SEC, 12'd0};
               cnt_in   = 6'd20;
               acc_in   = '0;
               state_in = ST_SPD_MUL;
            end
         end
         ST_SPD_MUL: begin
            acc_in = mac_sum;
            mpl_in = {mpl_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (last_step) begin
               rem_in   = '0;
               cnt_in   = 6'd53;
               state_in = ST_SPD_DIV;
            end
         end
         ST_SPD_DIV: begin
            // Quotient bits shift into the bottom as dividend bits leave the top.
            acc_in = {acc_ff[ACC_W-1:53], acc_ff[51:0], div_ge};
            rem_in = div_ge ? rem_sub[19:0] : rem_sh[19:0];
            cnt_in = cnt_ff - 6'd1;
            if (last_step) begin
               state_in = ST_SPD_SAT;
            end
         end
         ST_SPD_SAT: begin
            if (neg_ff) begin
               speed_in = big_neg ? SPEED_MIN : 48'(48'd0 - quo[47:0]);
            end else begin
               speed_in = big_pos ? SPEED_MAX : quo[47:0];
            end
            state_in = ST_AL_SETUP;
         end
         ST_AL_SETUP: begin
            mcand_in = ACC_W'(fc);
            mpl_in   = {us_ff, 12'd0};
            cnt_in   = 6'd20;
            acc_in   = '0;
            c_in     = ONE_SEC_Q36;
            state_in = ST_AL_MUL;
         end
         ST_AL_MUL: begin
            acc_in = mac_sum;
            mpl_in = {mpl_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (last_step) begin
               state_in = ST_AL_NORM;
            end
         end
         ST_AL_NORM: begin
            // Bring the time-cutoff product under 2^39, scaling the constant term with it.
            if (|acc_ff[ACC_W-1:39]) begin
               acc_in = {1'b0, acc_ff[ACC_W-1:1]};
               c_in   = {1'b0, c_ff[55:1]};
            end else begin
               mcand_in = {{(ACC_W-39){1'b0}}, acc_ff[38:0]};
               mpl_in   = {TWO_PI_Q20, 9'd0};
               cnt_in   = 6'd23;
               acc_in   = '0;
               state_in = ST_AL_PMUL;
            end
         end
         ST_AL_PMUL: begin
            acc_in = mac_sum;
            mpl_in = {mpl_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (last_step) begin
               state_in = ST_AL_DSET;
            end
         end
         ST_AL_DSET: begin
            mcand_in = {{(ACC_W-63){1'b0}}, 63'({7'd0, c_ff} + acc_ff[62:0])};
            mpl_in   = '0;
            cnt_in   = 6'd16;
            state_in = ST_AL_DIV;
         end
         ST_AL_DIV: begin
            acc_in = {{(ACC_W-64){1'b0}}, (al_ge ? r2_sub[63:0] : r2[63:0])};
            mpl_in = {mpl_ff[30:0], al_ge};
            cnt_in = cnt_ff - 6'd1;
            if (last_step) begin
               mpl_in   = {alpha, 16'd0};
               mcand_in = {{(ACC_W-49){dv[48]}}, dv};
               acc_in   = '0;
               cnt_in   = 6'd16;
               state_in = ST_BL_MUL;
            end
         end
         ST_BL_MUL: begin
            acc_in = mac_sum;
            mpl_in = {mpl_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (last_step) begin
               state_in = ST_BL_END;
            end
         end
         ST_BL_END: begin
            if (pass_ff) begin
               est_in   = bl_res[31:0];
               state_in = ST_OUT;
            end else begin
               spd_in   = bl_res[47:0];
               state_in = ST_GAIN_SET;
            end
         end
         ST_GAIN_SET: begin
            mcand_in = ACC_W'(smag);
            mpl_in   = gain_ff;
            cnt_in   = 6'd32;
            acc_in   = '0;
            state_in = ST_GAIN_MUL;
         end
         ST_GAIN_MUL: begin
            acc_in = mac_sum;
            mpl_in = {mpl_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (last_step) begin
               state_in = ST_CUT;
            end
         end
         ST_CUT: begin
            cut_in   = cut_sat ? 32'hFFFF_FFFF : cut_sum[31:0];
            pass_in  = 1'b1;
            state_in = ST_AL_SETUP;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = est_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_cut_ff   <= MIN_CUTOFF_RST;
         gain_ff      <= SPEED_GAIN_RST;
         dcut_ff      <= DERIV_CUTOFF_RST;
         est_ff       <= '0;
         spd_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         min_cut_ff   <= min_cut_in;
         gain_ff      <= gain_in;
         dcut_ff      <= dcut_in;
         est_ff       <= est_in;
         spd_ff       <= spd_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_filtered_ff <= rsp_filtered_in;
      x_ff            <= x_in;
      us_ff           <= us_in;
      restart_ff      <= restart_in;
      neg_ff          <= neg_in;
      pass_ff         <= pass_in;
      speed_ff        <= speed_in;
      cut_ff          <= cut_in;
      acc_ff          <= acc_in;
      mcand_ff        <= mcand_in;
      mpl_ff          <= mpl_in;
      cnt_ff          <= cnt_in;
      rem_ff          <= rem_in;
      c_ff            <= c_in;
   end

   `OEF_ASSERT_NXT(a_accept_starts, in_xfer, state_ff == ST_START, "transfer did not start")
   `OEF_ASSERT_IMP(a_speed_rem, state_ff == ST_SPD_DIV, rem_ff < us_ff, "bad speed remainder")
   `OEF_ASSERT_IMP(a_alpha_rem, state_ff == ST_AL_DIV, al_rem_ok, "bad alpha remainder")
   `OEF_ASSERT_IMP(a_primed_out, $rose(rsp_valid_ff), primed_ff, "result while not primed")
   `OEF_ASSERT_IMP(a_count_live, in_loop, cnt_ff != 6'd0, "step count ran out")

endmodule
